@@ rtl/vta_pkg.sv @@
// Shared constants, operation codes and types of the velocity to acceleration averager.
// Depends on nothing; every other file of the block imports it.
package vta_pkg;

   localparam int VEL_W    = 32;
   localparam int TIME_W   = 48;
   localparam int ACC_W    = 32;
   localparam int NUM_AXES = 3;
   localparam int RING_W   = NUM_AXES * ACC_W;

   // |dv| is at most 2^32, so |dv| * 1e9 stays below 2^62.
   localparam int MAG_W  = VEL_W + 1;
   localparam int PROD_W = 62;
   localparam int NS_W   = 30;
   localparam logic [NS_W-1:0] NS_PER_S = 30'd1000000000;

   localparam int DVSR_W    = TIME_W;
   localparam int DIV_CNT_W = $clog2(PROD_W + 1);

   localparam int WINDOW_LEN_DEFAULT = 8;

   localparam logic OP_SAMPLE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam logic [ACC_W-1:0] ACC_POS_MAX = {1'b0, {(ACC_W-1){1'b1}}};
   localparam logic [ACC_W-1:0] ACC_NEG_MIN = {1'b1, {(ACC_W-1){1'b0}}};

   typedef struct packed {
      logic                 start;
      logic [DIV_CNT_W-1:0] steps;
   } div_cmd_type;

endpackage

@@ rtl/vta_div.sv @@
// Shared restoring divider, one quotient bit per cycle, for the acceleration and mean paths.
// Depends on vta_pkg for widths and the command struct.
module vta_div (
   input  logic                          clock,
   input  logic                          reset,
   input  vta_pkg::div_cmd_type          cmd,
   input  logic [vta_pkg::PROD_W-1:0]    dividend,
   input  logic [vta_pkg::DVSR_W-1:0]    divisor,
   output logic                          done,
   output logic [vta_pkg::PROD_W-1:0]    quotient
);
   import vta_pkg::*;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0]    dvd_ff, dvd_in;
   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [DVSR_W-1:0]    rem_ff, rem_in;
   logic [DVSR_W-1:0]    dvsr_ff, dvsr_in;
   logic [DVSR_W:0]      trial;
   logic [DVSR_W:0]      diff;
   logic                 fits;

   always_comb begin
      trial = {rem_ff, dvd_ff[PROD_W-1]};
      diff  = trial - {1'b0, dvsr_ff};
      fits  = (trial >= {1'b0, dvsr_ff});

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dvsr_in = dvsr_ff;

      if (cmd.start) begin
         busy_in = 1'b1;
         cnt_in  = cmd.steps;
         dvd_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
         dvsr_in = divisor;
      end else if (busy_ff) begin
         // The remainder stays below the divisor, so 48 bits hold it either way.
         rem_in = fits ? diff[DVSR_W-1:0] : trial[DVSR_W-1:0];
         quo_in = {quo_ff[PROD_W-2:0], fits};
         dvd_in = {dvd_ff[PROD_W-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == DIV_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      dvd_ff  <= dvd_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
      dvsr_ff <= dvsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

@@ rtl/vta_ring.sv @@
// Ring of recent acceleration triples: one synchronous memory with a registered read port
// and a valid bit per slot, so reset and the clear command empty it at once. Uses vta_pkg.
module vta_ring #(
   parameter int DEPTH = vta_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             clear,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [vta_pkg::RING_W-1:0]       rd_data,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [vta_pkg::RING_W-1:0]       wr_data
);
   import vta_pkg::*;

   logic [RING_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [RING_W-1:0] rd_q_ff;
   logic              rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_q_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // A slot never written since reset or the last clear reads as zero.
   assign rd_data = rd_valid_ff ? rd_q_ff : '0;

endmodule

@@ rtl/velocity_to_acceleration_averager.sv @@
// Top level of the velocity to acceleration averager: request sequencer, per-axis state,
// running sums and result register. Depends on vta_pkg, vta_div and vta_ring.
//
// Usage:
//   Requests arrive on req_* with valid/stall. Opcode sample carries a 48-bit nanosecond
//   timestamp and three Q16.16 velocities; opcode clear zeroes the stored velocities, the
//   running sums and the acceleration ring and gives no result.
//   Each sample gives one result on rsp_*: the three instant accelerations (saturated,
//   with the clipped flag), the window means and the zero_interval flag.
//   One request is worked on at a time; req_stall is high from acceptance until the result
//   is loaded into the output register. A clear is done while idle and raises no req_stall.
//   For a sample, each axis goes through a multiply step and then a pass of the
//   shared restoring divider, one quotient bit per cycle over 62 bits. With a window length
//   that is not a power of two the means also go through the divider, one pass per axis.
//   A zero interval skips the multiply and the acceleration divisions.
//   The result register frees the input side: a new request is accepted while a result
//   still waits under rsp_stall, and its own result waits in the sequencer until the
//   register is taken.
//   Reset clears all history, the timestamp, the ring slot pointer and the valid bits of
//   the ring; no clearing pass is needed.
module velocity_to_acceleration_averager #(
   parameter int WINDOW_LEN = vta_pkg::WINDOW_LEN_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_opcode,
   input  logic [vta_pkg::TIME_W-1:0]        req_timestamp_ns,
   input  logic signed [vta_pkg::VEL_W-1:0]  req_vel_x,
   input  logic signed [vta_pkg::VEL_W-1:0]  req_vel_y,
   input  logic signed [vta_pkg::VEL_W-1:0]  req_vel_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [vta_pkg::ACC_W-1:0]  rsp_accel_x,
   output logic signed [vta_pkg::ACC_W-1:0]  rsp_accel_y,
   output logic signed [vta_pkg::ACC_W-1:0]  rsp_accel_z,
   output logic signed [vta_pkg::ACC_W-1:0]  rsp_avg_accel_x,
   output logic signed [vta_pkg::ACC_W-1:0]  rsp_avg_accel_y,
   output logic signed [vta_pkg::ACC_W-1:0]  rsp_avg_accel_z,
   output logic                              rsp_zero_interval,
   output logic                              rsp_clipped
);
   import vta_pkg::*;

   localparam int  SLOT_W    = $clog2(WINDOW_LEN);
   localparam int  SUM_W     = ACC_W + SLOT_W;
   localparam int  AVG_DVD_W = SUM_W + 1;
   localparam bit  AVG_POW2  = ((WINDOW_LEN & (WINDOW_LEN - 1)) == 0);

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_MUL       = 3'd1;
   localparam logic [2:0] S_DIV_START = 3'd2;
   localparam logic [2:0] S_DIV_WAIT  = 3'd3;
   localparam logic [2:0] S_SUM       = 3'd4;
   localparam logic [2:0] S_AVG_START = 3'd5;
   localparam logic [2:0] S_AVG_WAIT  = 3'd6;
   localparam logic [2:0] S_OUT       = 3'd7;

   logic [2:0]                state_ff, state_in;
   logic [1:0]                axis_ff, axis_in;
   logic [TIME_W-1:0]         last_time_ff, last_time_in;
   logic [TIME_W-1:0]         ts_ff, ts_in;
   logic [TIME_W-1:0]         dt_ff, dt_in;
   logic [SLOT_W-1:0]         slot_ff, slot_in;
   logic signed [VEL_W-1:0]   last_vel_ff [NUM_AXES];
   logic signed [VEL_W-1:0]   last_vel_in [NUM_AXES];
   logic signed [VEL_W-1:0]   vel_ff [NUM_AXES];
   logic signed [VEL_W-1:0]   vel_in [NUM_AXES];
   logic signed [ACC_W-1:0]   acc_ff [NUM_AXES];
   logic signed [ACC_W-1:0]   acc_in [NUM_AXES];
   logic signed [ACC_W-1:0]   avg_ff [NUM_AXES];
   logic signed [ACC_W-1:0]   avg_in [NUM_AXES];
   logic signed [SUM_W-1:0]   sum_ff [NUM_AXES];
   logic signed [SUM_W-1:0]   sum_in [NUM_AXES];
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic                      neg_ff, neg_in;
   logic                      zero_ff, zero_in;
   logic                      clip_ff, clip_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [ACC_W-1:0]   rsp_acc_ff [NUM_AXES];
   logic signed [ACC_W-1:0]   rsp_acc_in [NUM_AXES];
   logic signed [ACC_W-1:0]   rsp_avg_ff [NUM_AXES];
   logic signed [ACC_W-1:0]   rsp_avg_in [NUM_AXES];
   logic                      rsp_zero_ff, rsp_zero_in;
   logic                      rsp_clip_ff, rsp_clip_in;

   div_cmd_type               div_cmd;
   logic [PROD_W-1:0]         div_dividend;
   logic [DVSR_W-1:0]         div_divisor;
   logic                      div_done;
   logic [PROD_W-1:0]         div_quo;

   logic                      ring_clear;
   logic                      ring_rd_en;
   logic [RING_W-1:0]         ring_rd_data;
   logic                      ring_wr_en;
   logic [RING_W-1:0]         ring_wr_data;

   logic                      req_take;
   logic                      out_free;
   logic [MAG_W-1:0]          dv;
   logic [MAG_W-1:0]          mag;
   logic                      sat;
   logic [ACC_W-1:0]          q_low;
   logic signed [ACC_W-1:0]   old_acc;
   logic signed [SUM_W-1:0]   avg_src;
   logic [AVG_DVD_W-1:0]      avg_ext;
   logic [AVG_DVD_W-1:0]      avg_mag;

   vta_div u_div (
      .clock    (clock),
      .reset    (reset),
      .cmd      (div_cmd),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   vta_ring #(
      .DEPTH (WINDOW_LEN)
   ) u_ring (
      .clock   (clock),
      .reset   (reset),
      .clear   (ring_clear),
      .rd_en   (ring_rd_en),
      .rd_addr (slot_ff),
      .rd_data (ring_rd_data),
      .wr_en   (ring_wr_en),
      .wr_addr (slot_ff),
      .wr_data (ring_wr_data)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && (state_ff == S_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign ring_clear   = req_take && (req_opcode == OP_CLEAR);
   assign ring_rd_en   = req_take && (req_opcode == OP_SAMPLE);
   assign ring_wr_en   = (state_ff == S_SUM);
   assign ring_wr_data = {acc_ff[2], acc_ff[1], acc_ff[0]};

   always_comb begin
      dv  = {vel_ff[axis_ff][VEL_W-1], vel_ff[axis_ff]}
          - {last_vel_ff[axis_ff][VEL_W-1], last_vel_ff[axis_ff]};
      mag = dv[MAG_W-1] ? (~dv + 1'b1) : dv;

      avg_src = sum_ff[axis_ff];
      avg_ext = {avg_src[SUM_W-1], avg_src};
      // Floor of a negative mean: -ceil(|s| / N) = -((|s| + N - 1) / N).
      avg_mag = avg_src[SUM_W-1] ? (~avg_ext + 1'b1 + AVG_DVD_W'(WINDOW_LEN - 1)) : avg_ext;

      q_low = div_quo[ACC_W-1:0];
      if (neg_ff) begin
         sat = (|div_quo[PROD_W-1:ACC_W]) || (div_quo[ACC_W-1] && (|div_quo[ACC_W-2:0]));
      end else begin
         sat = |div_quo[PROD_W-1:ACC_W-1];
      end

      div_cmd.start = 1'b0;
      div_cmd.steps = DIV_CNT_W'(PROD_W);
      div_dividend  = prod_ff;
      div_divisor   = dt_ff;
      if (state_ff == S_DIV_START) begin
         div_cmd.start = 1'b1;
      end else if (state_ff == S_AVG_START) begin
         div_cmd.start = 1'b1;
         div_cmd.steps = DIV_CNT_W'(AVG_DVD_W);
         div_dividend  = PROD_W'(avg_mag) << (PROD_W - AVG_DVD_W);
         div_divisor   = DVSR_W'(WINDOW_LEN);
      end
   end

   always_comb begin
      state_in     = state_ff;
      axis_in      = axis_ff;
      last_time_in = last_time_ff;
      ts_in        = ts_ff;
      dt_in        = dt_ff;
      slot_in      = slot_ff;
      prod_in      = prod_ff;
      neg_in       = neg_ff;
      zero_in      = zero_ff;
      clip_in      = clip_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_zero_in  = rsp_zero_ff;
      rsp_clip_in  = rsp_clip_ff;
      old_acc      = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
         last_vel_in[a] = last_vel_ff[a];
         vel_in[a]      = vel_ff[a];
         acc_in[a]      = acc_ff[a];
         avg_in[a]      = avg_ff[a];
         sum_in[a]      = sum_ff[a];
         rsp_acc_in[a]  = rsp_acc_ff[a];
         rsp_avg_in[a]  = rsp_avg_ff[a];
      end

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               if (req_opcode == OP_CLEAR) begin
                  for (int a = 0; a < NUM_AXES; a++) begin
                     last_vel_in[a] = '0;
                     sum_in[a]      = '0;
                  end
               end else begin
                  ts_in     = req_timestamp_ns;
                  dt_in     = req_timestamp_ns - last_time_ff;
                  zero_in   = (req_timestamp_ns == last_time_ff);
                  clip_in   = 1'b0;
                  vel_in[0] = req_vel_x;
                  vel_in[1] = req_vel_y;
                  vel_in[2] = req_vel_z;
                  for (int a = 0; a < NUM_AXES; a++) begin
                     acc_in[a] = '0;
                  end
                  axis_in  = '0;
                  state_in = S_MUL;
               end
            end
         end
         S_MUL: begin
            if (zero_ff) begin
               state_in = S_SUM;
            end else begin
               neg_in   = dv[MAG_W-1];
               prod_in  = PROD_W'(mag) * PROD_W'(NS_PER_S);
               state_in = S_DIV_START;
            end
         end
         S_DIV_START: begin
            state_in = S_DIV_WAIT;
         end
         S_DIV_WAIT: begin
            if (div_done) begin
               if (sat) begin
                  acc_in[axis_ff] = neg_ff ? ACC_NEG_MIN : ACC_POS_MAX;
                  clip_in         = 1'b1;
               end else begin
                  acc_in[axis_ff] = neg_ff ? (~q_low + 1'b1) : q_low;
               end
               if (axis_ff == 2'(NUM_AXES - 1)) begin
                  state_in = S_SUM;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_MUL;
               end
            end
         end
         S_SUM: begin
            for (int a = 0; a < NUM_AXES; a++) begin
               old_acc        = ring_rd_data[a*ACC_W +: ACC_W];
               sum_in[a]      = sum_ff[a] + SUM_W'(acc_ff[a]) - SUM_W'(old_acc);
               last_vel_in[a] = vel_ff[a];
            end
            last_time_in = ts_ff;
            slot_in      = (slot_ff == SLOT_W'(WINDOW_LEN - 1)) ? '0 : slot_ff + 1'b1;
            axis_in      = '0;
            state_in     = AVG_POW2 ? S_OUT : S_AVG_START;
         end
         S_AVG_START: begin
            neg_in   = avg_src[SUM_W-1];
            state_in = S_AVG_WAIT;
         end
         S_AVG_WAIT: begin
            if (div_done) begin
               avg_in[axis_ff] = neg_ff ? (~q_low + 1'b1) : q_low;
               if (axis_ff == 2'(NUM_AXES - 1)) begin
                  state_in = S_OUT;
               end else begin
                  axis_in  = axis_ff + 1'b1;
                  state_in = S_AVG_START;
               end
            end
         end
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_zero_in  = zero_ff;
               rsp_clip_in  = clip_ff;
               for (int a = 0; a < NUM_AXES; a++) begin
                  rsp_acc_in[a] = acc_ff[a];
                  rsp_avg_in[a] = AVG_POW2 ? ACC_W'(sum_ff[a] >>> SLOT_W) : avg_ff[a];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         axis_ff      <= '0;
         last_time_ff <= '0;
         slot_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int a = 0; a < NUM_AXES; a++) begin
            last_vel_ff[a] <= '0;
            sum_ff[a]      <= '0;
         end
      end else begin
         state_ff     <= state_in;
         axis_ff      <= axis_in;
         last_time_ff <= last_time_in;
         slot_ff      <= slot_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int a = 0; a < NUM_AXES; a++) begin
            last_vel_ff[a] <= last_vel_in[a];
            sum_ff[a]      <= sum_in[a];
         end
      end
      ts_ff       <= ts_in;
      dt_ff       <= dt_in;
      prod_ff     <= prod_in;
      neg_ff      <= neg_in;
      zero_ff     <= zero_in;
      clip_ff     <= clip_in;
      rsp_zero_ff <= rsp_zero_in;
      rsp_clip_ff <= rsp_clip_in;
      for (int a = 0; a < NUM_AXES; a++) begin
         vel_ff[a]     <= vel_in[a];
         acc_ff[a]     <= acc_in[a];
         avg_ff[a]     <= avg_in[a];
         rsp_acc_ff[a] <= rsp_acc_in[a];
         rsp_avg_ff[a] <= rsp_avg_in[a];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_accel_x       = rsp_acc_ff[0];
   assign rsp_accel_y       = rsp_acc_ff[1];
   assign rsp_accel_z       = rsp_acc_ff[2];
   assign rsp_avg_accel_x   = rsp_avg_ff[0];
   assign rsp_avg_accel_y   = rsp_avg_ff[1];
   assign rsp_avg_accel_z   = rsp_avg_ff[2];
   assign rsp_zero_interval = rsp_zero_ff;
   assign rsp_clipped       = rsp_clip_ff;

endmodule
